>>> sv/tsw_pkg.sv
// shared types, constants and the sine table of the three voice wavetable synth
`default_nettype none

package tsw_pkg;

	// stream payload layout
	localparam int FREQ_W     = 16;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 8;
	localparam int DUTY_W     = 8;

	// tick divider, one sample per SAMPLE_DIVIDE ticks
	localparam int SAMPLE_DIVIDE = 8;
	localparam int TICK_W        = $clog2(SAMPLE_DIVIDE);
	localparam logic [TICK_W-1:0] SAMPLE_LAST = TICK_W'(SAMPLE_DIVIDE - 1);

	// phase accumulators and wavetable
	localparam int PHASE_W     = 16;
	localparam int TABLE_DEPTH = 64;
	localparam int PHASE_IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [7:0] SINE_ROM [TABLE_DEPTH] = '{
		8'd128, 8'd140, 8'd152, 8'd165, 8'd176, 8'd187, 8'd197, 8'd206,
		8'd213, 8'd220, 8'd225, 8'd229, 8'd231, 8'd233, 8'd233, 8'd231,
		8'd229, 8'd225, 8'd220, 8'd213, 8'd206, 8'd197, 8'd187, 8'd176,
		8'd165, 8'd152, 8'd140, 8'd128, 8'd116, 8'd104, 8'd91,  8'd80,
		8'd69,  8'd59,  8'd50,  8'd43,  8'd36,  8'd31,  8'd27,  8'd25,
		8'd23,  8'd23,  8'd25,  8'd27,  8'd31,  8'd36,  8'd43,  8'd50,
		8'd59,  8'd69,  8'd80,  8'd91,  8'd104, 8'd116, 8'd128, 8'd128,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
	};

	// phase step = floor(freq * ratio), ratio held as ceil(ratio * 2^30)
	localparam int STEP_SHIFT = 30;
	localparam int RECIP_W    = 30;
	localparam int STEP_PROD_W = FREQ_W + RECIP_W;
	localparam logic [RECIP_W-1:0] ROOT_RECIP  = 30'd548656303; // 7984/15625
	localparam logic [RECIP_W-1:0] THIRD_RECIP = 30'd549755814; // 64/125
	localparam logic [RECIP_W-1:0] FIFTH_RECIP = 30'd550855326; // 8016/15625
	localparam logic [FREQ_W-1:0]  SILENT_ROOT = 16'd800;

	// envelope
	localparam int ENV_W      = 8;
	localparam int ENV_TICK_W = 3;
	localparam logic [ENV_W-1:0] ENV_STEP = 8'd4;
	localparam logic [ENV_W-1:0] ENV_PEAK = 8'd200;

	// drums
	localparam int LEVEL_W = 16;
	localparam int DECAY_W = 15;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 16'h8000;
	localparam logic [LEVEL_W-1:0] LEVEL_FLOOR = 16'd327;
	localparam logic [DECAY_W-1:0] SNARE_DECAY = 15'd30147;
	localparam logic [DECAY_W-1:0] HAT_DECAY   = 15'd28836;
	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;
	localparam int NOISE_W = 8;
	localparam logic signed [NOISE_W-1:0] NOISE_BIAS = 8'sd64;

	// mixing
	localparam int SUM_W        = 10;
	localparam logic [9:0] RECIP3 = 10'd683;
	localparam int RECIP3_SHIFT = 11;
	localparam int MIX_W        = 11;
	localparam logic signed [MIX_W-1:0] MIX_MID = 11'sd128;
	localparam logic signed [MIX_W-1:0] PWM_MIN = 11'sd5;
	localparam logic signed [MIX_W-1:0] PWM_MAX = 11'sd250;

	// request that starts the mixing pipe, with its drum noise
	typedef struct packed {
		logic                              valid;
		logic                              noise_on;
		logic signed [NOISE_W-1:0]         noise;
		logic [LEVEL_W-1:0]                level;
	} drum_t;

	function automatic logic [7:0] wave_at(input logic [PHASE_W-1:0] phase);
		wave_at = SINE_ROM[phase[PHASE_W-1 -: PHASE_IDX_W]];
	endfunction

endpackage

`default_nettype wire

>>> sv/tsw_mix.sv
// mixing pipe: wavetable lookup, voice average, envelope, drum noise and clamp
`default_nettype none

module tsw_mix (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tsw_pkg::drum_t                 drum_s1,
	input  logic [tsw_pkg::PHASE_W-1:0]    root_phase,
	input  logic [tsw_pkg::PHASE_W-1:0]    third_phase,
	input  logic [tsw_pkg::PHASE_W-1:0]    fifth_phase,
	input  logic [tsw_pkg::ENV_W-1:0]      env_level,
	output logic                           pwm_valid,
	output logic [tsw_pkg::DUTY_W-1:0]     pwm_duty
);
	import tsw_pkg::*;

	drum_t drum_s2, drum_s3, drum_s4;

	logic [SUM_W-1:0]           wave_sum;
	logic [SUM_W+9:0]           avg_prod;
	logic [7:0]                 avg_s3;
	logic signed [8:0]          dev;
	logic signed [17:0]         env_prod_s4;
	logic signed [24:0]         noise_prod_s4;
	logic signed [17:0]         env_div;
	logic signed [24:0]         noise_div;
	logic signed [MIX_W-1:0]    env_term;
	logic signed [MIX_W-1:0]    noise_term;
	logic signed [MIX_W-1:0]    mix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drum_s2 <= '0;
			drum_s3 <= '0;
			drum_s4 <= '0;
		end else begin
			drum_s2 <= drum_s1;
			drum_s3 <= drum_s2;
			drum_s4 <= drum_s3;
		end
	end

	// s2: phases already hold this sample's update
	always_comb begin
		wave_sum = SUM_W'(wave_at(root_phase)) + SUM_W'(wave_at(third_phase))
			+ SUM_W'(wave_at(fifth_phase));
		avg_prod = (SUM_W+10)'(wave_sum) * (SUM_W+10)'(RECIP3);
	end

	always_ff @(posedge clk) begin
		avg_s3 <= avg_prod[RECIP3_SHIFT +: 8];
	end

	// s3: envelope and noise products
	assign dev = $signed({1'b0, avg_s3}) - 9'sd128;

	always_ff @(posedge clk) begin
		env_prod_s4   <= dev * $signed({1'b0, env_level});
		noise_prod_s4 <= $signed(drum_s3.noise) * $signed({1'b0, drum_s3.level});
	end

	// s4: divide with truncation toward zero, sum and clamp
	always_comb begin
		env_div    = (env_prod_s4 + (env_prod_s4[17] ? 18'sd255 : 18'sd0)) >>> 8;
		noise_div  = (noise_prod_s4 + (noise_prod_s4[24] ? 25'sd32767 : 25'sd0)) >>> 15;
		env_term   = $signed(env_div[MIX_W-1:0]);
		noise_term = drum_s4.noise_on ? $signed(noise_div[MIX_W-1:0]) : '0;
		mix        = MIX_MID + env_term + noise_term;
		if (mix > PWM_MAX) begin
			mix = PWM_MAX;
		end else if (mix < PWM_MIN) begin
			mix = PWM_MIN;
		end
		pwm_duty  = mix[DUTY_W-1:0];
		pwm_valid = drum_s4.valid;
	end

endmodule

`default_nettype wire

>>> sv/three_voice_wavetable_synth.sv
// three voice wavetable synth: tick handling, phase and envelope state, output register
//
// every accepted request on the s_axis side is one timer tick. every eighth tick
// makes one pwm duty sample on the m_axis side; the other ticks give nothing.
// snare and hat strikes take effect on the tick that carries them, sample or not.
// a tick can be accepted in every cycle. ticks that make no sample are taken even
// while a sample waits at the output; a sample tick waits only while the output
// register is full and not being drained.
// a sample is written to the output register through these steps in order:
// the steps, phases and envelope, then lookup and average,
// envelope and noise products, and finally truncating division, sum and clamp.
// the receiver may stall for any length of time; the waiting sample holds.
// after reset all phases, steps and levels are zero, the noise generator holds
// its seed and the first sample comes on the eighth tick.
`default_nettype none

module three_voice_wavetable_synth (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// root_freq, third_freq, fifth_freq, drums_enabled, snare_strike, hat_strike
	input  logic [tsw_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// pwm_duty
	output logic [tsw_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
	import tsw_pkg::*;

	logic [FREQ_W-1:0]  root_freq, third_freq, fifth_freq;
	logic               drums_enabled, snare_strike, hat_strike;
	logic               accept, sample;

	logic [TICK_W-1:0]     tick_q;
	logic [FREQ_W-1:0]     prev_root_q;
	logic [PHASE_W-1:0]    root_step_q, third_step_q, fifth_step_q;
	logic [PHASE_W-1:0]    root_phase_q, third_phase_q, fifth_phase_q;
	logic [ENV_W-1:0]      env_q;
	logic [ENV_TICK_W-1:0] env_tick_q;
	logic                  was_active_q;
	logic [15:0]           noise_q;
	logic [LEVEL_W-1:0]    snare_q, hat_q;
	logic                  out_valid_q;
	logic [DUTY_W-1:0]     out_data_q;

	// s1 registers
	logic [PHASE_W-1:0] root_new_s1, third_new_s1, fifth_new_s1;
	logic               change_s1, loud_s1;
	drum_t              drum_s1;

	logic [STEP_PROD_W-1:0] root_prod, third_prod, fifth_prod;
	logic [LEVEL_W-1:0]     snare_pre, hat_pre, snare_dec, hat_dec;
	logic [LEVEL_W+DECAY_W-1:0] snare_prod, hat_prod;
	logic [15:0]            lfsr_next;
	logic                   noise_on;
	drum_t                  drum_d;

	logic [PHASE_W-1:0]    root_step_d, third_step_d, fifth_step_d;
	logic                  active;
	logic [ENV_W-1:0]      env_base, env_d;
	logic [ENV_TICK_W-1:0] env_tick_d;

	logic                  pwm_valid;
	logic [DUTY_W-1:0]     pwm_duty;

	assign root_freq     = s_axis_tdata[FREQ_W-1:0];
	assign third_freq    = s_axis_tdata[2*FREQ_W-1:FREQ_W];
	assign fifth_freq    = s_axis_tdata[3*FREQ_W-1:2*FREQ_W];
	assign drums_enabled = s_axis_tdata[3*FREQ_W];
	assign snare_strike  = s_axis_tdata[3*FREQ_W+1];
	assign hat_strike    = s_axis_tdata[3*FREQ_W+2];

	assign sample        = (tick_q == SAMPLE_LAST);
	assign s_axis_tready = !sample || !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// tick stage: strikes, drum noise and step products
	always_comb begin
		snare_pre  = snare_strike ? LEVEL_FULL : snare_q;
		hat_pre    = hat_strike ? LEVEL_FULL : hat_q;
		noise_on   = drums_enabled && ((snare_pre > LEVEL_FLOOR) || (hat_pre > LEVEL_FLOOR));
		lfsr_next  = (noise_q >> 1) ^ (noise_q[0] ? LFSR_TAPS : 16'h0000);
		snare_prod = (LEVEL_W+DECAY_W)'(snare_pre) * (LEVEL_W+DECAY_W)'(SNARE_DECAY);
		hat_prod   = (LEVEL_W+DECAY_W)'(hat_pre) * (LEVEL_W+DECAY_W)'(HAT_DECAY);
		snare_dec  = snare_prod[DECAY_W +: LEVEL_W];
		hat_dec    = hat_prod[DECAY_W +: LEVEL_W];
		root_prod  = STEP_PROD_W'(root_freq) * STEP_PROD_W'(ROOT_RECIP);
		third_prod = STEP_PROD_W'(third_freq) * STEP_PROD_W'(THIRD_RECIP);
		fifth_prod = STEP_PROD_W'(fifth_freq) * STEP_PROD_W'(FIFTH_RECIP);

		drum_d.valid    = accept && sample;
		drum_d.noise_on = noise_on;
		drum_d.noise    = $signed({1'b0, lfsr_next[NOISE_W-2:0]}) - NOISE_BIAS;
		drum_d.level    = (snare_pre > hat_pre) ? snare_pre : hat_pre;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			prev_root_q <= '0;
			noise_q     <= LFSR_SEED;
			snare_q     <= '0;
			hat_q       <= '0;
			drum_s1     <= '0;
		end else begin
			drum_s1 <= drum_d;
			if (accept) begin
				if (sample) begin
					tick_q      <= '0;
					prev_root_q <= root_freq;
					if (noise_on) begin
						noise_q <= lfsr_next;
						snare_q <= snare_dec;
						hat_q   <= hat_dec;
					end else begin
						snare_q <= snare_pre;
						hat_q   <= hat_pre;
					end
				end else begin
					tick_q  <= tick_q + 1'b1;
					snare_q <= snare_pre;
					hat_q   <= hat_pre;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && sample) begin
			root_new_s1  <= root_prod[STEP_SHIFT +: PHASE_W];
			third_new_s1 <= third_prod[STEP_SHIFT +: PHASE_W];
			fifth_new_s1 <= fifth_prod[STEP_SHIFT +: PHASE_W];
			change_s1    <= (root_freq != prev_root_q);
			loud_s1      <= (root_freq > SILENT_ROOT);
		end
	end

	// s1: steps, phases and envelope
	always_comb begin
		root_step_d  = root_step_q;
		third_step_d = third_step_q;
		fifth_step_d = fifth_step_q;
		if (change_s1) begin
			root_step_d  = loud_s1 ? root_new_s1 : '0;
			third_step_d = loud_s1 ? third_new_s1 : '0;
			fifth_step_d = loud_s1 ? fifth_new_s1 : '0;
		end
		active     = (root_step_d != '0);
		env_base   = (active && !was_active_q) ? '0 : env_q;
		env_tick_d = env_tick_q + 1'b1;
		env_d      = env_base;
		if (env_tick_d == '0) begin
			if (active) begin
				if (env_base < ENV_PEAK) begin
					env_d = env_base + ENV_STEP;
				end
			end else begin
				env_d = (env_base > ENV_STEP) ? env_base - ENV_STEP : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_step_q   <= '0;
			third_step_q  <= '0;
			fifth_step_q  <= '0;
			root_phase_q  <= '0;
			third_phase_q <= '0;
			fifth_phase_q <= '0;
			env_q         <= '0;
			env_tick_q    <= '0;
			was_active_q  <= 1'b0;
		end else if (drum_s1.valid) begin
			root_step_q   <= root_step_d;
			third_step_q  <= third_step_d;
			fifth_step_q  <= fifth_step_d;
			root_phase_q  <= root_phase_q + root_step_d;
			third_phase_q <= third_phase_q + third_step_d;
			fifth_phase_q <= fifth_phase_q + fifth_step_d;
			env_q         <= env_d;
			env_tick_q    <= env_tick_d;
			was_active_q  <= active;
		end
	end

	tsw_mix u_mix (
		.clk         (clk),
		.arst_n      (arst_n),
		.drum_s1     (drum_s1),
		.root_phase  (root_phase_q),
		.third_phase (third_phase_q),
		.fifth_phase (fifth_phase_q),
		.env_level   (env_q),
		.pwm_valid   (pwm_valid),
		.pwm_duty    (pwm_duty)
	);

	// output register, free whenever a sample arrives from the mixing pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pwm_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pwm_valid) begin
			out_data_q <= pwm_duty;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

>>> dv/tb_three_voice_wavetable_synth.sv
// self-checking testbench for the three voice wavetable synth with a duty-cycle predictor
`timescale 1ns / 1ps

module tb_three_voice_wavetable_synth;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int TICKS_PER_SAMPLE = 8;
	localparam logic [15:0] SILENT_MAX = 16'd800;
	localparam logic [15:0] NOISE_TAPS = 16'hB400;
	localparam logic [15:0] NOISE_SEED = 16'hACE1;
	localparam logic [15:0] LEVEL_MAX = 16'h8000;
	localparam int DRUM_FLOOR = 327;
	localparam int ENV_TOP    = 200;

	localparam logic [7:0] WAVE [64] = '{
		8'd128, 8'd140, 8'd152, 8'd165, 8'd176, 8'd187, 8'd197, 8'd206,
		8'd213, 8'd220, 8'd225, 8'd229, 8'd231, 8'd233, 8'd233, 8'd231,
		8'd229, 8'd225, 8'd220, 8'd213, 8'd206, 8'd197, 8'd187, 8'd176,
		8'd165, 8'd152, 8'd140, 8'd128, 8'd116, 8'd104, 8'd91,  8'd80,
		8'd69,  8'd59,  8'd50,  8'd43,  8'd36,  8'd31,  8'd27,  8'd25,
		8'd23,  8'd23,  8'd25,  8'd27,  8'd31,  8'd36,  8'd43,  8'd50,
		8'd59,  8'd69,  8'd80,  8'd91,  8'd104, 8'd116, 8'd128, 8'd128,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
	};

	// tick request, last field in the lowest bits
	typedef struct packed {
		logic [4:0]  pad;
		logic        hat;
		logic        snare;
		logic        drums;
		logic [15:0] fifth;
		logic [15:0] third;
		logic [15:0] root;
	} tick_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic [tsw_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic s_axis_tready;
	logic m_axis_tvalid;
	logic m_tready = 1'b0;
	logic [tsw_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	three_voice_wavetable_synth u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted synth state
	int          tick_count = 0;
	logic [15:0] phase_r = '0, phase_t = '0, phase_f = '0;
	logic [15:0] step_r = '0, step_t = '0, step_f = '0;
	logic [15:0] last_root = '0;
	int          env_level = 0;
	logic [2:0]  env_tick = '0;
	bit          prev_active = 1'b0;
	logic [15:0] noise_lfsr = NOISE_SEED;
	logic [15:0] snare_lvl = '0, hat_lvl = '0;

	logic [7:0] duty_queue [$];
	int mismatch_count = 0;
	int samples_seen = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit gaps_on = 1'b1;
	int burst_left = 0;

	task automatic advance_synth(input tick_t t);
		bit          active;
		int          sum, mix, noise, lvl;
		if (t.snare) snare_lvl = LEVEL_MAX;
		if (t.hat) hat_lvl = LEVEL_MAX;
		tick_count++;
		if (tick_count < TICKS_PER_SAMPLE) return;
		tick_count = 0;

		// steps are only reworked when the root moves
		if (t.root != last_root) begin
			last_root = t.root;
			if (t.root > SILENT_MAX) begin
				step_r = 16'((64'(t.root) * 64'd8175616) / 64'd16000000);
				step_t = 16'((64'(t.third) * 64'd512) / 64'd1000);
				step_f = 16'((64'(t.fifth) * 64'd8208384) / 64'd16000000);
			end else begin
				step_r = '0;
				step_t = '0;
				step_f = '0;
			end
		end

		active = step_r != 0;
		if (active && !prev_active) env_level = 0;
		env_tick = env_tick + 3'd1;
		if (env_tick == 3'd0) begin
			if (active) begin
				if (env_level < ENV_TOP) env_level = env_level + 4;
			end else begin
				env_level = (env_level > 4) ? env_level - 4 : 0;
			end
		end
		prev_active = active;

		phase_r = phase_r + step_r;
		phase_t = phase_t + step_t;
		phase_f = phase_f + step_f;

		sum = (int'(WAVE[phase_r[15:10]]) + int'(WAVE[phase_t[15:10]])
			+ int'(WAVE[phase_f[15:10]])) / 3;
		mix = 128 + ((sum - 128) * env_level) / 256;

		if (t.drums && (snare_lvl > DRUM_FLOOR || hat_lvl > DRUM_FLOOR)) begin
			noise_lfsr = (noise_lfsr >> 1) ^ (noise_lfsr[0] ? NOISE_TAPS : 16'h0000);
			noise = int'(noise_lfsr[6:0]) - 64;
			lvl = (snare_lvl > hat_lvl) ? int'(snare_lvl) : int'(hat_lvl);
			mix = mix + (noise * lvl) / 32768;
			snare_lvl = 16'((32'(snare_lvl) * 32'd30147) >> 15);
			hat_lvl = 16'((32'(hat_lvl) * 32'd28836) >> 15);
		end

		if (mix > 250) mix = 250;
		if (mix < 5) mix = 5;
		duty_queue.push_back(8'(mix));
	endtask

	function automatic tick_t make_tick(input logic [15:0] root, input logic [15:0] third,
			input logic [15:0] fifth, input logic drums, input logic snare, input logic hat);
		tick_t t;
		t = '{pad: 5'd0, hat: hat, snare: snare, drums: drums,
			fifth: fifth, third: third, root: root};
		return t;
	endfunction

	function automatic logic [15:0] pick_root();
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(0, 800));
			1: return 16'($urandom_range(798, 803));
			2, 3: return 16'($urandom);
			default: return 16'($urandom_range(1000, 24000));
		endcase
	endfunction

	// one tick request, then, when gaps are on, a random gap at the end of a burst
	task automatic send_tick(input tick_t t);
		s_tvalid <= 1'b1;
		s_tdata <= t;
		do @(posedge clk); while (!s_axis_tready);
		advance_synth(t);
		if (gaps_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic wait_for_samples();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (duty_queue.size() != 0);
	endtask

	task automatic report_mismatch(input string what);
		$display("%0t: %s", $time, what);
		mismatch_count++;
	endtask

	// silence at reset, the silent threshold both sides and field extremes
	task automatic test_power_on_and_edges();
		repeat (8) send_tick(make_tick(16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0));
		send_tick(make_tick(16'd801, 16'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0));
		send_tick(make_tick(16'd801, 16'd0, 16'hFFFF, 1'b0, 1'b1, 1'b0));
		repeat (5) send_tick(make_tick(16'd801, 16'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0));
		send_tick(make_tick(16'd801, 16'd0, 16'hFFFF, 1'b1, 1'b0, 1'b0));
		repeat (7) send_tick(make_tick(16'hFFFF, 16'hFFFF, 16'd0, 1'b1, 1'b0, 1'b0));
		send_tick(make_tick(16'hFFFF, 16'hFFFF, 16'd0, 1'b1, 1'b0, 1'b1));
		repeat (7) send_tick(make_tick(16'd800, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0));
		send_tick(make_tick(16'd800, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1));
	endtask

	// held chord lets the envelope climb while the drums die out
	task automatic test_sustained_chord();
		logic [15:0] root, third, fifth;
		root = 16'($urandom_range(2000, 12000));
		third = 16'($urandom_range(2000, 16000));
		fifth = 16'($urandom_range(2000, 20000));
		for (int i = 0; i < 560; i++)
			send_tick(make_tick(root, third, fifth, 1'b1,
				i < 120 && $urandom_range(0, 39) == 0,
				i == 0 || (i < 120 && $urandom_range(0, 39) == 0)));
	endtask

	// silent roots let the envelope fall, drums on for the second half
	task automatic test_release();
		for (int i = 0; i < 200; i++)
			send_tick(make_tick(16'($urandom_range(0, 800)), 16'($urandom), 16'($urandom),
				1'(i >= 100), $urandom_range(0, 49) == 0, $urandom_range(0, 49) == 0));
	endtask

	// held chords of random length, with some phrases of pure noise
	task automatic test_random_phrases(input int target);
		int          sent;
		int          len;
		bit          noisy;
		logic [15:0] root, third, fifth;
		logic        drums;
		sent = 0;
		while (sent < target) begin
			len = $urandom_range(8, 80);
			noisy = $urandom_range(0, 9) == 0;
			root = pick_root();
			third = 16'($urandom);
			fifth = 16'($urandom);
			if ($urandom_range(0, 1)) begin
				third = 16'($urandom_range(1000, 24000));
				fifth = 16'($urandom_range(1000, 24000));
			end
			drums = 1'($urandom_range(0, 2) != 0);
			gaps_on = $urandom_range(0, 3) != 0;
			for (int i = 0; i < len; i++) begin
				if (noisy) begin
					root = 16'($urandom);
					third = 16'($urandom);
					fifth = 16'($urandom);
					drums = 1'($urandom);
				end else if ($urandom_range(0, 15) == 0) begin
					// upper voices move without the root, steps must stay put
					third = 16'($urandom);
					fifth = 16'($urandom);
				end
				send_tick(make_tick(root, third, fifth, drums,
					$urandom_range(0, 23) == 0, $urandom_range(0, 23) == 0));
			end
			sent += len;
		end
		gaps_on = 1'b1;
	endtask

	// receiver holds off while ticks keep coming, so the input must stall
	task automatic test_output_backpressure();
		logic [15:0] root;
		root = 16'($urandom_range(1000, 24000));
		gaps_on = 1'b0;
		hold_left = 400;
		for (int i = 0; i < 160; i++)
			send_tick(make_tick(root, 16'($urandom), 16'($urandom), 1'b1,
				$urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0));
		gaps_on = 1'b1;
	endtask

	// receiver stalls on a rotating random pattern, or for a long hold-off
	initial begin
		logic [15:0] ready_pattern;
		int          pattern_pos;
		ready_pattern = '1;
		pattern_pos = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (pattern_pos == 0)
					ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
						: 16'($urandom | $urandom);
				m_tready <= ready_pattern[pattern_pos];
				pattern_pos = (pattern_pos + 1) % 16;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_tready) begin
			if (duty_queue.size() == 0) begin
				report_mismatch($sformatf("duty %0d arrived with no sample predicted",
					m_axis_tdata));
			end else begin
				if (m_axis_tdata !== duty_queue[0])
					report_mismatch($sformatf("sample %0d: duty %0d, predicted %0d",
						samples_seen, m_axis_tdata, duty_queue[0]));
				void'(duty_queue.pop_front());
			end
			samples_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_on_and_edges();
		wait_for_samples();
		test_sustained_chord();
		wait_for_samples();
		test_release();
		test_random_phrases(220);
		wait_for_samples();
		test_output_backpressure();
		test_random_phrases(220);
		wait_for_samples();
		repeat (12) @(posedge clk);
		if (mismatch_count == 0 && duty_queue.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
